>>> rtl/core/brfo_pkg.sv
// ----------------------------------------------------------------------------
// brfo_pkg
// Shared types and constants for the byte ring FIFO with overwrite.
// ----------------------------------------------------------------------------
package brfo_pkg;

    localparam int DATA_W        = 8;
    localparam int CNT_W         = 7;
    localparam int CMD_W         = 2;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT  = 2'd0,
        CMD_GET  = 2'd1,
        CMD_POP  = 2'd2,
        CMD_PEEK = 2'd3
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic step;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic go_stream;
        logic remain_last;
    } dp_stat_t;

endpackage

>>> rtl/core/byte_ring_fifo_overwrite.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_overwrite
// Byte ring FIFO with run-time capacity; put overwrites the oldest byte when
// full, get/peek stream bytes oldest first, pop discards.
//
// Channel   Handshake        Fields
// request   start / busy     command, data_in, count
// result    strobe           data_out, last, moved, level, space
// config    cfg_we           cfg_wdata (capacity)
//
// A result is registered and appears in the cycle after its request is accepted.
// Put, pop and empty requests leave busy low; back-to-back puts run every cycle when idle.
// Get/peek of n bytes streams one RAM read per cycle; busy is high while the
// bytes after the first are read. Reset empties the ring and sets capacity to DEPTH.
// The result side has no stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module byte_ring_fifo_overwrite #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [brfo_pkg::CMD_W-1:0]    command,
    input  logic [brfo_pkg::DATA_W-1:0]   data_in,
    input  logic [brfo_pkg::CNT_W-1:0]    count,
    input  logic                          cfg_we,
    input  logic [brfo_pkg::CNT_W-1:0]    cfg_wdata,
    output logic                          strobe,
    output logic [brfo_pkg::DATA_W-1:0]   data_out,
    output logic                          last,
    output logic [brfo_pkg::CNT_W-1:0]    moved,
    output logic [brfo_pkg::CNT_W-1:0]    level,
    output logic [brfo_pkg::CNT_W-1:0]    space
);

    brfo_pkg::ctl_cmd_t ctl;
    brfo_pkg::dp_stat_t stat;

    brfo_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    brfo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .command   (command),
        .data_in   (data_in),
        .count     (count),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .strobe    (strobe),
        .data_out  (data_out),
        .last      (last),
        .moved     (moved),
        .level     (level),
        .space     (space)
    );

endmodule

>>> rtl/core/brfo_ram.sv
// ----------------------------------------------------------------------------
// brfo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/brfo_ctrl.sv
// ----------------------------------------------------------------------------
// brfo_ctrl
// Request controller: accepts requests and sequences multi-byte reads.
// ----------------------------------------------------------------------------
module brfo_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  brfo_pkg::dp_stat_t  stat,
    output brfo_pkg::ctl_cmd_t  ctl,
    output logic                busy
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctl.accept = start && (state_reg == ST_IDLE);
        ctl.step   = (state_reg == ST_READ);
        busy       = (state_reg == ST_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.accept && stat.go_stream)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (stat.remain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/brfo_dp.sv
// ----------------------------------------------------------------------------
// brfo_dp
// Datapath: ring pointers, fill level, capacity, ring RAM and result registers.
// ----------------------------------------------------------------------------
module brfo_dp #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brfo_pkg::ctl_cmd_t            ctl,
    output brfo_pkg::dp_stat_t            stat,
    input  logic [brfo_pkg::CMD_W-1:0]    command,
    input  logic [brfo_pkg::DATA_W-1:0]   data_in,
    input  logic [brfo_pkg::CNT_W-1:0]    count,
    input  logic                          cfg_we,
    input  logic [brfo_pkg::CNT_W-1:0]    cfg_wdata,
    output logic                          strobe,
    output logic [brfo_pkg::DATA_W-1:0]   data_out,
    output logic                          last,
    output logic [brfo_pkg::CNT_W-1:0]    moved,
    output logic [brfo_pkg::CNT_W-1:0]    level,
    output logic [brfo_pkg::CNT_W-1:0]    space
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = brfo_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [AW-1:0] wi_reg,     wi_next;
    logic [CW-1:0] fill_reg,   fill_next;
    logic [CW-1:0] cap_reg,    cap_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic [CW-1:0] n_reg,      n_next;

    logic          strobe_reg,   strobe_next;
    logic          from_ram_reg, from_ram_next;
    logic          last_reg,     last_next;
    logic [CW-1:0] moved_reg,    moved_next;
    logic [CW-1:0] level_reg,    level_next;
    logic [CW-1:0] space_reg,    space_next;

    brfo_pkg::cmd_t cmd;
    logic [CW-1:0]  n_req;
    logic [CW:0]    rd_sum;
    logic [CW:0]    rd_mod;
    logic [AW-1:0]  rd0;
    logic [AW-1:0]  rd0_inc;
    logic [AW-1:0]  rd_ptr_inc;
    logic [AW-1:0]  wi_inc;
    logic           ram_we;
    logic [AW-1:0]  raddr;
    logic [brfo_pkg::DATA_W-1:0] rdata;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] p1;
        p1 = CW'(p) + CW'(1);
        ring_inc = (p1 == cap) ? '0 : p1[AW-1:0];
    endfunction

    always_comb
    begin
        cmd        = brfo_pkg::cmd_t'(command);
        n_req      = (count < fill_reg) ? count : fill_reg;
        // oldest byte: (wi + cap - level) mod cap, sum stays below 2*cap
        rd_sum     = (CW+1)'(wi_reg) + (CW+1)'(cap_reg) - (CW+1)'(fill_reg);
        rd_mod     = (rd_sum >= (CW+1)'(cap_reg)) ? rd_sum - (CW+1)'(cap_reg) : rd_sum;
        rd0        = rd_mod[AW-1:0];
        rd0_inc    = ring_inc(rd0, cap_reg);
        rd_ptr_inc = ring_inc(rd_ptr_reg, cap_reg);
        wi_inc     = ring_inc(wi_reg, cap_reg);
    end

    always_comb
    begin
        wi_next       = wi_reg;
        fill_next     = fill_reg;
        cap_next      = cap_reg;
        rd_ptr_next   = rd_ptr_reg;
        remain_next   = remain_reg;
        n_next        = n_reg;
        strobe_next   = 1'b0;
        from_ram_next = 1'b0;
        last_next     = last_reg;
        moved_next    = moved_reg;
        level_next    = level_reg;
        space_next    = space_reg;
        ram_we        = 1'b0;
        raddr         = rd0;
        stat.go_stream   = 1'b0;
        stat.remain_last = (remain_reg == CW'(1));

        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                cap_next = CW'(1);
            end
            else if (cfg_wdata > DEPTH_C)
            begin
                cap_next = DEPTH_C;
            end
            else
            begin
                cap_next = cfg_wdata;
            end
            wi_next   = '0;
            fill_next = '0;
        end
        else if (ctl.step)
        begin
            raddr         = rd_ptr_reg;
            rd_ptr_next   = rd_ptr_inc;
            remain_next   = remain_reg - CW'(1);
            strobe_next   = 1'b1;
            from_ram_next = 1'b1;
            last_next     = (remain_reg == CW'(1));
            moved_next    = n_reg;
        end
        else if (ctl.accept)
        begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            if (cmd == brfo_pkg::CMD_PUT)
            begin
                ram_we  = 1'b1;
                wi_next = wi_inc;
                if (fill_reg < cap_reg)
                begin
                    fill_next = fill_reg + CW'(1);
                end
                moved_next = CW'(1);
            end
            else if (n_req == '0)
            begin
                moved_next = '0;
            end
            else if (cmd == brfo_pkg::CMD_POP)
            begin
                fill_next  = fill_reg - n_req;
                moved_next = n_req;
            end
            else
            begin
                if (cmd == brfo_pkg::CMD_GET)
                begin
                    fill_next = fill_reg - n_req;
                end
                from_ram_next  = 1'b1;
                moved_next     = n_req;
                last_next      = (n_req == CW'(1));
                rd_ptr_next    = rd0_inc;
                remain_next    = n_req - CW'(1);
                n_next         = n_req;
                stat.go_stream = (n_req != CW'(1));
            end
            level_next = fill_next;
            space_next = cap_reg - fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg       <= '0;
            fill_reg     <= '0;
            cap_reg      <= DEPTH_C;
            remain_reg   <= '0;
            strobe_reg   <= 1'b0;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            wi_reg       <= wi_next;
            fill_reg     <= fill_next;
            cap_reg      <= cap_next;
            remain_reg   <= remain_next;
            strobe_reg   <= strobe_next;
            from_ram_reg <= from_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        n_reg      <= n_next;
        last_reg   <= last_next;
        moved_reg  <= moved_next;
        level_reg  <= level_next;
        space_reg  <= space_next;
    end

    brfo_ram #(
        .WIDTH (brfo_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata (data_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign strobe   = strobe_reg;
    assign data_out = from_ram_reg ? rdata : '0;
    assign last     = last_reg;
    assign moved    = moved_reg;
    assign level    = level_reg;
    assign space    = space_reg;

endmodule

>>> tb/tb_byte_ring_fifo_overwrite.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_overwrite
// Self-checking bench for the overwrite byte ring FIFO. Requests are queued by
// the sequence block and fed to the block by a clocked driver. A shadow ring
// predicts every result when a request is accepted. A clocked monitor compares
// each strobed result field by field with the oldest prediction. The run
// covers a directed part and random phases at several capacities, including
// 0, 127 and the reset value. Sender gaps vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_overwrite;

    localparam int RING_DEPTH = 64;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        brfo_pkg::cmd_t op;
        logic [7:0]     din;
        logic [6:0]     cnt;
    } ring_request_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [6:0] moved;
        logic [6:0] level;
        logic [6:0] space;
    } ring_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    brfo_pkg::cmd_t command = brfo_pkg::CMD_PUT;
    logic [7:0]     data_in = '0;
    logic [6:0]     count = '0;
    logic           cfg_we = 1'b0;
    logic [6:0]     cfg_wdata = '0;
    logic           strobe;
    logic [7:0]     data_out;
    logic           last;
    logic [6:0]     moved;
    logic [6:0]     level;
    logic [6:0]     space;

    ring_request_t req_backlog[$];
    ring_result_t  expected_results[$];

    logic [7:0] shadow_ring [0:RING_DEPTH-1];
    int         shadow_wr;
    int         shadow_fill;
    logic [6:0] shadow_capacity;

    int gap_pct = 0;
    int errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_settings = 0;
    int quiet_cycles = 0;

    byte_ring_fifo_overwrite #(.DEPTH(RING_DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .data_in   (data_in),
        .count     (count),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .strobe    (strobe),
        .data_out  (data_out),
        .last      (last),
        .moved     (moved),
        .level     (level),
        .space     (space)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int effective_capacity(input logic [6:0] raw);
        if (raw == 7'd0)
            return 1;
        if (int'(raw) > RING_DEPTH)
            return RING_DEPTH;
        return int'(raw);
    endfunction

    task automatic push_result(input logic [7:0] d, input logic lst, input int mv,
                               input int cap);
        ring_result_t r;
        r.data  = d;
        r.last  = lst;
        r.moved = 7'(mv);
        r.level = 7'(shadow_fill);
        r.space = 7'(cap - shadow_fill);
        expected_results.push_back(r);
    endtask

    task automatic predict_ring_request(input brfo_pkg::cmd_t op, input logic [7:0] din,
                                        input logic [6:0] cnt);
        int cap;
        int n;
        int rd;
        cap = effective_capacity(shadow_capacity);
        n = (int'(cnt) < shadow_fill) ? int'(cnt) : shadow_fill;
        if (op == brfo_pkg::CMD_PUT)
        begin
            shadow_ring[shadow_wr % RING_DEPTH] = din;
            shadow_wr = (shadow_wr + 1) % cap;
            if (shadow_fill < cap)
                shadow_fill++;
            push_result(8'h00, 1'b1, 1, cap);
        end
        else if (n == 0)
        begin
            push_result(8'h00, 1'b1, 0, cap);
        end
        else if (op == brfo_pkg::CMD_POP)
        begin
            shadow_fill -= n;
            push_result(8'h00, 1'b1, n, cap);
        end
        else
        begin
            rd = (shadow_wr + cap - shadow_fill) % cap;
            if (op == brfo_pkg::CMD_GET)
                shadow_fill -= n;
            for (int i = 0; i < n; i++)
                push_result(shadow_ring[((rd + i) % cap) % RING_DEPTH],
                            (i + 1 == n), n, cap);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // driver: a new request goes out once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        ring_request_t req;
        if (!rst_n)
        begin
            start   <= 1'b0;
            command <= brfo_pkg::CMD_PUT;
            data_in <= '0;
            count   <= '0;
        end
        else if (!start || !busy)
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                req = req_backlog.pop_front();
                start   <= 1'b1;
                command <= req.op;
                data_in <= req.din;
                count   <= req.cnt;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check strobed results, predict on each accepted request
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, expected none, got data %0d",
                             $time, data_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("data_out", want.data, data_out);
                    check_field("last", want.last, last);
                    check_field("moved", want.moved, moved);
                    check_field("level", want.level, level);
                    check_field("space", want.space, space);
                end
            end
            if (start && !busy)
            begin
                n_requests++;
                predict_ring_request(command, data_in, count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic add_request(input brfo_pkg::cmd_t op, input logic [7:0] din,
                               input logic [6:0] cnt);
        ring_request_t r;
        r.op  = op;
        r.din = din;
        r.cnt = cnt;
        req_backlog.push_back(r);
    endtask

    task automatic drain_all();
        while (req_backlog.size() != 0 || start || expected_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [6:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_capacity = value;
        shadow_wr = 0;
        shadow_fill = 0;
        n_settings++;
        @(negedge clk);
    endtask

    // mostly puts, single or in bursts, mixed with reads of counts mostly 1 to capacity + 2
    task automatic add_random_requests(input int total, input int cap);
        int added;
        int burst;
        int pick;
        added = 0;
        while (added < total)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                burst = $urandom_range(1, cap + 3);
                if (burst > total - added)
                    burst = total - added;
                repeat (burst) add_request(brfo_pkg::CMD_PUT, 8'($urandom), 7'($urandom));
                added += burst;
            end
            else if (pick < 55)
            begin
                add_request(brfo_pkg::CMD_PUT, 8'($urandom), 7'($urandom));
                added++;
            end
            else
            begin
                pick = $urandom_range(9);
                add_request(brfo_pkg::cmd_t'($urandom_range(1, 3)), 8'($urandom),
                            (pick == 0) ? 7'd0 :
                            (pick == 1) ? 7'($urandom_range(64, 127)) :
                                          7'($urandom_range(1, cap + 2)));
                added++;
            end
        end
    endtask

    initial
    begin
        logic [6:0] caps [9];
        int         gaps [3];
        caps = '{7'd127, 7'd0, 7'd1, 7'd5, 7'd17, 7'd64, 7'd100, 7'd63, 7'd33};
        gaps = '{0, 70, 18};
        for (int i = 0; i < RING_DEPTH; i++)
            shadow_ring[i] = 8'h00;
        shadow_wr = 0;
        shadow_fill = 0;
        shadow_capacity = 7'd64;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reads on the empty ring at reset capacity, then puts and reads past the level
        add_request(brfo_pkg::CMD_GET, 8'h00, 7'd0);
        add_request(brfo_pkg::CMD_PEEK, 8'hFF, 7'd5);
        add_request(brfo_pkg::CMD_POP, 8'h00, 7'd127);
        add_request(brfo_pkg::CMD_PUT, 8'h00, 7'd0);
        add_request(brfo_pkg::CMD_PUT, 8'hFF, 7'd127);
        add_request(brfo_pkg::CMD_PUT, 8'hA5, 7'd0);
        add_request(brfo_pkg::CMD_PUT, 8'h5A, 7'd0);
        add_request(brfo_pkg::CMD_PEEK, 8'h00, 7'd127);
        add_request(brfo_pkg::CMD_GET, 8'h00, 7'd1);
        add_request(brfo_pkg::CMD_POP, 8'h00, 7'd1);
        add_request(brfo_pkg::CMD_GET, 8'h00, 7'd64);
        add_request(brfo_pkg::CMD_GET, 8'h00, 7'd1);
        drain_all();

        // tiny ring: overwrite when full, zero count with data held
        write_capacity(7'd2);
        add_request(brfo_pkg::CMD_PUT, 8'h11, 7'd0);
        add_request(brfo_pkg::CMD_PUT, 8'h22, 7'd0);
        add_request(brfo_pkg::CMD_PUT, 8'h33, 7'd0);
        add_request(brfo_pkg::CMD_PUT, 8'h44, 7'd0);
        add_request(brfo_pkg::CMD_PEEK, 8'h00, 7'd2);
        add_request(brfo_pkg::CMD_GET, 8'h00, 7'd127);
        add_request(brfo_pkg::CMD_PUT, 8'h55, 7'd0);
        add_request(brfo_pkg::CMD_POP, 8'h00, 7'd0);
        add_request(brfo_pkg::CMD_PEEK, 8'h00, 7'd1);
        add_request(brfo_pkg::CMD_GET, 8'h00, 7'd1);
        drain_all();

        for (int p = 0; p < 9; p++)
        begin
            write_capacity(caps[p]);
            gap_pct = gaps[p % 3];
            add_random_requests(18, effective_capacity(caps[p]));
            drain_all();
            add_random_requests(18, effective_capacity(caps[p]));
            drain_all();
        end
        gap_pct = 0;
        repeat (4) @(negedge clk);

        $display("covered %0d requests and %0d results over %0d capacity settings",
                 n_requests, n_results, n_settings);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
